// File: design/m2u_pkg.sv
// Shared types, constants and lookup functions for the MGRS to UTM converter.
package m2u_pkg;

  localparam logic [23:0] SQUARE_M = 24'd100000;
  localparam logic [23:0] RAISE_M  = 24'd2000000;
  localparam logic [16:0] SQUARE_OFF = 17'd100000;

  localparam logic [7:0] LTR_A = "A";
  localparam logic [7:0] LTR_F = "F";
  localparam logic [7:0] LTR_I = "I";
  localparam logic [7:0] LTR_J = "J";
  localparam logic [7:0] LTR_O = "O";
  localparam logic [7:0] LTR_S = "S";
  localparam logic [7:0] LTR_V = "V";
  localparam logic [7:0] LTR_Z = "Z";

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_COLUMN = 2'd1,
    ERR_ROW    = 2'd2,
    ERR_BAND   = 2'd3
  } m2u_err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COL,
    ST_ROW_START,
    ST_ROW,
    ST_RAISE,
    ST_ADD_N,
    ST_ADD_E,
    ST_DONE
  } m2u_state_t;

  typedef struct packed {
    logic [5:0]  zone_number;
    logic [7:0]  band_letter;
    logic [7:0]  column_letter;
    logic [7:0]  row_letter;
    logic [16:0] east_offset;
    logic [16:0] north_offset;
  } m2u_in_t;

  typedef struct packed {
    logic [22:0] utm_easting;
    logic [23:0] utm_northing;
    m2u_err_t    error_code;
  } m2u_out_t;

  // Control from the top level to the core.
  typedef struct packed {
    logic start;
    logic out_free;
  } m2u_ctl_t;

  // Status from the core to the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } m2u_sts_t;

  typedef struct packed {
    logic        ok;
    logic [23:0] minn;
  } m2u_band_t;

  // The column origin repeats every three zones: A, J, S.
  // Since 4 is 1 mod 3, summing the 2-bit digits keeps the residue.
  function automatic logic [7:0] col_origin(input logic [5:0] zone);
    logic [3:0] s;
    begin
      s = {2'b00, zone[1:0]} + {2'b00, zone[3:2]} + {2'b00, zone[5:4]};
      if (s inside {4'd1, 4'd4, 4'd7}) begin
        col_origin = LTR_A;
      end else if (s inside {4'd2, 4'd5, 4'd8}) begin
        col_origin = LTR_J;
      end else begin
        col_origin = LTR_S;
      end
    end
  endfunction

  // Odd sets start rows at A, even sets at F; the set has the parity of the zone.
  function automatic logic [7:0] row_origin(input logic [5:0] zone);
    row_origin = zone[0] ? LTR_A : LTR_F;
  endfunction

  function automatic m2u_band_t band_min(input logic [7:0] band);
    m2u_band_t r;
    begin
      r.ok = 1'b1;
      case (band)
        "C": r.minn = 24'd1100000;
        "D": r.minn = 24'd2000000;
        "E": r.minn = 24'd2800000;
        "F": r.minn = 24'd3700000;
        "G": r.minn = 24'd4600000;
        "H": r.minn = 24'd5500000;
        "J": r.minn = 24'd6400000;
        "K": r.minn = 24'd7300000;
        "L": r.minn = 24'd8200000;
        "M": r.minn = 24'd9100000;
        "N": r.minn = 24'd0;
        "P": r.minn = 24'd800000;
        "Q": r.minn = 24'd1700000;
        "R": r.minn = 24'd2600000;
        "S": r.minn = 24'd3500000;
        "T": r.minn = 24'd4400000;
        "U": r.minn = 24'd5300000;
        "V": r.minn = 24'd6200000;
        "W": r.minn = 24'd7000000;
        "X": r.minn = 24'd7900000;
        default: begin
          r.ok   = 1'b0;
          r.minn = 24'd0;
        end
      endcase
      band_min = r;
    end
  endfunction

endpackage

// File: design/mgrs_to_utm.sv
// MGRS to UTM converter top level: request handshakes and the result register.
//
// A request on the in_ channel carries one MGRS reference: zone, band letter,
// the two 100 km square letters and the metre offsets inside the square. It is
// taken at a rising edge with in_valid high and in_stall low. The result on the
// out_ channel gives UTM easting, northing and an error code; on an error the
// offsets are returned unchanged.
// The time from acceptance to the result being registered is set by the letter
// walks, one grid letter per cycle through a shared step unit, and by the
// northing raise, one 2000 km addition per cycle through the shared adder.
// in_stall stays high for that whole time, so only one request is in flight.
// The result sits in an output register; the next request is accepted while a
// finished result still waits there. If the receiver holds out_stall, the
// result and out_valid hold, and a following result waits in the core until
// the register frees.
// A synchronous reset (rst_n low) returns the sequencer to idle and drops
// out_valid; the data registers are not reset.
module mgrs_to_utm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  m2u_pkg::m2u_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output m2u_pkg::m2u_out_t out_data
);

  m2u_pkg::m2u_ctl_t  ctl;
  m2u_pkg::m2u_sts_t  sts;
  m2u_pkg::m2u_out_t  res;
  logic               out_valid_r, out_valid_nxt;
  m2u_pkg::m2u_out_t  out_data_r, out_data_nxt;

  assign ctl.start    = in_valid && !sts.busy;
  assign ctl.out_free = !out_valid_r || !out_stall;
  assign in_stall     = sts.busy;

  m2u_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .in_item (in_data),
    .sts     (sts),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (sts.done) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/m2u_letter_step.sv
// One step of the grid letter walk: advance, skip I and O, wrap once after the top letter.
module m2u_letter_step (
  input  logic [7:0] cur,
  input  logic       wrapped,
  input  logic [7:0] top,
  output logic [7:0] next_letter,
  output logic       next_wrapped,
  output logic       fail
);

  logic [7:0] n0;
  logic [7:0] n1;
  logic [7:0] n2;

  always_comb begin
    n0 = cur + 8'd1;
    n1 = (n0 == m2u_pkg::LTR_I) ? n0 + 8'd1 : n0;
    n2 = (n1 == m2u_pkg::LTR_O) ? n1 + 8'd1 : n1;
    fail         = 1'b0;
    next_letter  = n2;
    next_wrapped = wrapped;
    if (n2 > top) begin
      // A second pass past the top letter means the target is not on the grid.
      fail         = wrapped;
      next_letter  = m2u_pkg::LTR_A;
      next_wrapped = 1'b1;
    end
  end

endmodule

// File: design/m2u_alu.sv
// Shared adder and magnitude compare used by every arithmetic step of the sequencer.
module m2u_alu (
  input  logic [23:0] add_a,
  input  logic [23:0] add_b,
  input  logic [23:0] cmp_b,
  output logic [23:0] sum,
  output logic        lt
);

  assign sum = add_a + add_b;
  assign lt  = add_a < cmp_b;

endmodule

// File: design/m2u_core.sv
// Sequencer and datapath that walk the square letters and build easting and northing.
module m2u_core (
  input  logic               clk,
  input  logic               rst_n,
  input  m2u_pkg::m2u_ctl_t  ctl,
  input  m2u_pkg::m2u_in_t   in_item,
  output m2u_pkg::m2u_sts_t  sts,
  output m2u_pkg::m2u_out_t  res
);

  m2u_pkg::m2u_state_t state_r, state_nxt;
  m2u_pkg::m2u_in_t    item_r, item_nxt;
  m2u_pkg::m2u_err_t   err_r, err_nxt;
  logic [7:0]          cur_r, cur_nxt;
  logic                wrapped_r, wrapped_nxt;
  logic [23:0]         acc_r, acc_nxt;
  logic [22:0]         east_base_r, east_base_nxt;
  logic [22:0]         east_r, east_nxt;
  logic [23:0]         north_r, north_nxt;

  logic [7:0]          walk_top;
  logic [7:0]          walk_target;
  logic                walk_match;
  logic [7:0]          step_letter;
  logic                step_wrapped;
  logic                step_fail;
  logic [23:0]         alu_b;
  logic [23:0]         alu_sum;
  logic                alu_lt;
  logic [16:0]         eoff_mod;
  logic [16:0]         noff_mod;
  m2u_pkg::m2u_band_t  band;

  assign walk_top    = (state_r == m2u_pkg::ST_COL) ? m2u_pkg::LTR_Z : m2u_pkg::LTR_V;
  assign walk_target = (state_r == m2u_pkg::ST_COL) ? item_r.column_letter
                                                    : item_r.row_letter;
  assign walk_match  = (cur_r == walk_target);
  assign band        = m2u_pkg::band_min(item_r.band_letter);

  // Offsets are below twice the square size, so one conditional subtract reduces them.
  assign eoff_mod = (item_r.east_offset >= m2u_pkg::SQUARE_OFF)
                  ? item_r.east_offset - m2u_pkg::SQUARE_OFF : item_r.east_offset;
  assign noff_mod = (item_r.north_offset >= m2u_pkg::SQUARE_OFF)
                  ? item_r.north_offset - m2u_pkg::SQUARE_OFF : item_r.north_offset;

  m2u_letter_step u_step (
    .cur          (cur_r),
    .wrapped      (wrapped_r),
    .top          (walk_top),
    .next_letter  (step_letter),
    .next_wrapped (step_wrapped),
    .fail         (step_fail)
  );

  always_comb begin
    case (state_r)
      m2u_pkg::ST_RAISE: alu_b = m2u_pkg::RAISE_M;
      m2u_pkg::ST_ADD_N: alu_b = {7'd0, noff_mod};
      m2u_pkg::ST_ADD_E: alu_b = {7'd0, eoff_mod};
      default:           alu_b = m2u_pkg::SQUARE_M;
    endcase
  end

  m2u_alu u_alu (
    .add_a (acc_r),
    .add_b (alu_b),
    .cmp_b (band.minn),
    .sum   (alu_sum),
    .lt    (alu_lt)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      m2u_pkg::ST_IDLE: begin
        if (ctl.start) begin
          state_nxt = m2u_pkg::ST_COL;
        end
      end
      m2u_pkg::ST_COL: begin
        if (walk_match) begin
          state_nxt = m2u_pkg::ST_ROW_START;
        end else if (step_fail) begin
          state_nxt = m2u_pkg::ST_DONE;
        end
      end
      m2u_pkg::ST_ROW_START: begin
        if (item_r.row_letter > m2u_pkg::LTR_V) begin
          state_nxt = m2u_pkg::ST_DONE;
        end else begin
          state_nxt = m2u_pkg::ST_ROW;
        end
      end
      m2u_pkg::ST_ROW: begin
        if (walk_match) begin
          state_nxt = band.ok ? m2u_pkg::ST_RAISE : m2u_pkg::ST_DONE;
        end else if (step_fail) begin
          state_nxt = m2u_pkg::ST_DONE;
        end
      end
      m2u_pkg::ST_RAISE: begin
        if (!alu_lt) begin
          state_nxt = m2u_pkg::ST_ADD_N;
        end
      end
      m2u_pkg::ST_ADD_N: state_nxt = m2u_pkg::ST_ADD_E;
      m2u_pkg::ST_ADD_E: state_nxt = m2u_pkg::ST_DONE;
      m2u_pkg::ST_DONE: begin
        if (ctl.out_free) begin
          state_nxt = m2u_pkg::ST_IDLE;
        end
      end
      default: state_nxt = m2u_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates and status.
  always_comb begin
    item_nxt      = item_r;
    err_nxt       = err_r;
    cur_nxt       = cur_r;
    wrapped_nxt   = wrapped_r;
    acc_nxt       = acc_r;
    east_base_nxt = east_base_r;
    east_nxt      = east_r;
    north_nxt     = north_r;
    sts.busy      = (state_r != m2u_pkg::ST_IDLE);
    sts.done      = 1'b0;
    case (state_r)
      m2u_pkg::ST_IDLE: begin
        if (ctl.start) begin
          item_nxt    = in_item;
          err_nxt     = m2u_pkg::ERR_NONE;
          cur_nxt     = m2u_pkg::col_origin(in_item.zone_number);
          wrapped_nxt = 1'b0;
          acc_nxt     = m2u_pkg::SQUARE_M;
        end
      end
      m2u_pkg::ST_COL, m2u_pkg::ST_ROW: begin
        if (!walk_match) begin
          if (step_fail) begin
            err_nxt = (state_r == m2u_pkg::ST_COL) ? m2u_pkg::ERR_COLUMN
                                                   : m2u_pkg::ERR_ROW;
          end else begin
            cur_nxt     = step_letter;
            wrapped_nxt = step_wrapped;
            acc_nxt     = alu_sum;
          end
        end else if (state_r == m2u_pkg::ST_ROW && !band.ok) begin
          err_nxt = m2u_pkg::ERR_BAND;
        end
      end
      m2u_pkg::ST_ROW_START: begin
        east_base_nxt = acc_r[22:0];
        acc_nxt       = 24'd0;
        cur_nxt       = m2u_pkg::row_origin(item_r.zone_number);
        wrapped_nxt   = 1'b0;
        if (item_r.row_letter > m2u_pkg::LTR_V) begin
          err_nxt = m2u_pkg::ERR_ROW;
        end
      end
      m2u_pkg::ST_RAISE: begin
        if (alu_lt) begin
          acc_nxt = alu_sum;
        end
      end
      m2u_pkg::ST_ADD_N: begin
        north_nxt = alu_sum;
        acc_nxt   = {1'b0, east_base_r};
      end
      m2u_pkg::ST_ADD_E: begin
        east_nxt = alu_sum[22:0];
      end
      m2u_pkg::ST_DONE: begin
        sts.done = ctl.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= m2u_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    item_r      <= item_nxt;
    err_r       <= err_nxt;
    cur_r       <= cur_nxt;
    wrapped_r   <= wrapped_nxt;
    acc_r       <= acc_nxt;
    east_base_r <= east_base_nxt;
    east_r      <= east_nxt;
    north_r     <= north_nxt;
  end

  // On any error the offsets pass through as given.
  always_comb begin
    res.error_code = err_r;
    if (err_r == m2u_pkg::ERR_NONE) begin
      res.utm_easting  = east_r;
      res.utm_northing = north_r;
    end else begin
      res.utm_easting  = {6'd0, item_r.east_offset};
      res.utm_northing = {7'd0, item_r.north_offset};
    end
  end

endmodule
